// ===== sv/i2csr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_pkg
// Types and constants shared by the I2C sensor register slave.
// ----------------------------------------------------------------------------
package i2csr_pkg;

    // bus event codes
    localparam logic [1:0] ACT_STOP  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // reply kinds
    localparam logic REPLY_ACK  = 1'b0;
    localparam logic REPLY_DATA = 1'b1;

    localparam logic [7:0] ACK_BYTE    = 8'h01;
    localparam logic [7:0] IDENT_INDEX = 8'h75;
    localparam logic [7:0] IDENT_VALUE = 8'h68;
    localparam logic [7:0] SENSOR_BASE = 8'h3B;
    localparam logic [3:0] SENSOR_LAST = 4'd13;
    localparam logic [6:0] ADDR_RESET  = 7'h34;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  bus_address;
        logic [7:0]  write_data;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] temperature;
        logic [15:0] gyro_x;
        logic [15:0] gyro_y;
        logic [15:0] gyro_z;
    } t_in_item;

    typedef struct packed {
        logic       reply_kind;
        logic [7:0] reply_data;
    } t_out_item;

    // register map access issued by the controller
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_mem_req;

endpackage

// ===== sv/i2c_sensor_register_slave_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_sensor_register_slave_unit
// Byte-level I2C slave with an auto-incrementing register map.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one bus event
//   per request: stop, start, write byte or read byte, plus the address byte
//   and a sensor snapshot. Output channel (o_out_valid / i_out_ready /
//   o_out_item) returns an acknowledge or a read byte. Stops and events for
//   another slave address give no reply.
//   A read waits for the synchronous register-map read; a start writes
//   fourteen sensor bytes through the single write port of the map, one
//   per cycle.
//   The reply is registered and leaves from the output register.
//   A finished reply waits in the output register while the next request is
//   taken; if a second reply is ready before the first leaves, the
//   sequencer holds it and stops taking requests until the output frees.
//   i_cfg_wr_en writes the seven-bit slave address at once, no handshake.
//   Reset is synchronous: pointer, phase and per-entry valid bits clear,
//   so all entries but the identity register read as zero, no clearing pass.
// ----------------------------------------------------------------------------
module i2c_sensor_register_slave_unit #(
    parameter int REG_COUNT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2csr_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2csr_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [6:0]            i_cfg_wr_data
);
    import i2csr_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    logic [6:0] r_dev_addr;
    logic       w_addr_match;
    t_mem_req   w_mem;
    logic [7:0] w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    // ignore the read/write flag
    assign w_addr_match = (r_dev_addr == i_in_item.bus_address[7:1]);

    i2csr_ctrl #(
        .REG_COUNT (REG_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_addr_match (w_addr_match),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item),
        .o_mem_req    (w_mem),
        .i_mem_rdata  (w_mem_rdata)
    );

    i2csr_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr[AW-1:0]),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr[AW-1:0]),
        .o_rdata (w_mem_rdata)
    );

    // a map read is issued only for an accepted request
    a_read_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.re |-> (i_in_valid && o_in_ready))
        else $error("map read without accepted request");

    // the cycle after a read the sequencer is busy with the read data
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.re |=> !o_in_ready)
        else $error("request taken during read-back");

    // never read and write the map in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.we |-> !w_mem.re)
        else $error("map read and write overlap");

    // writes stay inside the map
    a_write_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.we |-> ({1'b0, w_mem.waddr} < 9'(REG_COUNT)))
        else $error("map write out of range");

endmodule

// ===== sv/i2csr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module i2csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/i2csr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_ctrl
// Event sequencer: register pointer, entry valid bits, sensor load sweep,
// read-back and the output register.
// ----------------------------------------------------------------------------
module i2csr_ctrl #(
    parameter int REG_COUNT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2csr_pkg::t_in_item   i_in_item,
    input  logic                  i_addr_match,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2csr_pkg::t_out_item  o_out_item,
    output i2csr_pkg::t_mem_req   o_mem_req,
    input  logic [7:0]            i_mem_rdata
);
    import i2csr_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RDATA,
        ST_WAIT
    } t_state;

    t_state                 r_state,     n_state;
    logic [7:0]             r_ptr,       n_ptr;
    logic                   r_idx_rcv,   n_idx_rcv;
    logic [REG_COUNT-1:0]   r_vld,       n_vld;
    logic [3:0]             r_cnt,       n_cnt;
    t_in_item               r_snap,      n_snap;
    t_out_item              r_res,       n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,       n_out;
    logic                   r_rd_ident,  n_rd_ident;
    logic                   r_rd_hit,    n_rd_hit;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_ptr_in;
    logic [AW-1:0]          w_ptr_idx;
    logic [111:0]           w_sens_vec;
    logic [111:0]           w_sens_shift;
    logic [7:0]             w_load_addr;
    logic                   w_res_go;
    t_out_item              w_res_item;
    t_mem_req               w_mem;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_ptr_in   = ({1'b0, r_ptr} < 9'(REG_COUNT));
    assign w_ptr_idx  = r_ptr[AW-1:0];

    // readings big-endian, first byte on top
    assign w_sens_vec   = {r_snap.accel_x, r_snap.accel_y, r_snap.accel_z,
                           r_snap.temperature, r_snap.gyro_x, r_snap.gyro_y,
                           r_snap.gyro_z};
    assign w_sens_shift = w_sens_vec << {r_cnt, 3'b000};
    assign w_load_addr  = SENSOR_BASE + {4'b0000, r_cnt};

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_idx_rcv   = r_idx_rcv;
        n_vld       = r_vld;
        n_cnt       = r_cnt;
        n_snap      = r_snap;
        n_res       = r_res;
        n_out       = r_out;
        n_rd_ident  = r_rd_ident;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && !i_out_ready;
        w_res_go    = 1'b0;
        w_res_item  = '{reply_kind: REPLY_ACK, reply_data: ACK_BYTE};
        w_mem       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_addr_match) begin
                    unique case (i_in_item.action)
                        ACT_START: begin
                            n_idx_rcv = 1'b0;
                            n_cnt     = '0;
                            n_snap    = i_in_item;
                            n_state   = ST_LOAD;
                        end
                        ACT_WRITE: begin
                            if (!r_idx_rcv) begin
                                n_ptr     = i_in_item.write_data;
                                n_idx_rcv = 1'b1;
                            end else begin
                                // drop the byte when the pointer is past the map
                                if (w_ptr_in) begin
                                    w_mem.we         = 1'b1;
                                    w_mem.waddr      = r_ptr;
                                    w_mem.wdata      = i_in_item.write_data;
                                    n_vld[w_ptr_idx] = 1'b1;
                                end
                                n_ptr = r_ptr + 8'd1;
                            end
                            w_res_go = 1'b1;
                        end
                        ACT_READ: begin
                            w_mem.re   = 1'b1;
                            w_mem.raddr = r_ptr;
                            n_rd_ident = (r_ptr == IDENT_INDEX);
                            n_rd_hit   = w_ptr_in && r_vld[w_ptr_idx];
                            n_ptr      = r_ptr + 8'd1;
                            n_state    = ST_RDATA;
                        end
                        ACT_STOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = w_load_addr;
                w_mem.wdata = w_sens_shift[111:104];
                n_vld[w_load_addr[AW-1:0]] = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == SENSOR_LAST) begin
                    w_res_go = 1'b1;
                end
            end
            ST_RDATA: begin
                w_res_go = 1'b1;
                w_res_item.reply_kind = REPLY_DATA;
                if (r_rd_ident) begin
                    w_res_item.reply_data = IDENT_VALUE;
                end else if (r_rd_hit) begin
                    w_res_item.reply_data = i_mem_rdata;
                end else begin
                    w_res_item.reply_data = 8'h00;
                end
            end
            ST_WAIT: begin
                w_res_go   = 1'b1;
                w_res_item = r_res;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or hold it until free
        if (w_res_go) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out       = w_res_item;
                n_state     = ST_IDLE;
            end else begin
                n_res   = w_res_item;
                n_state = ST_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap     <= n_snap;
        r_res      <= n_res;
        r_out      <= n_out;
        r_rd_ident <= n_rd_ident;
        r_rd_hit   <= n_rd_hit;
        r_cnt      <= n_cnt;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_idx_rcv   <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_idx_rcv   <= n_idx_rcv;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_mem_req   = w_mem;

endmodule
